>>> design/mca_pkg.sv
// ----------------------------------------------------------------------------
// mca_pkg
// Types, sizes and helpers shared by the min-cost assignment solver.
// ----------------------------------------------------------------------------
package mca_pkg;

  localparam int MaxRows    = 8;
  localparam int MaxColumns = 16;
  localparam int CostBits   = 32;
  localparam int StoreDepth = MaxRows * MaxColumns;
  localparam int AddrBits   = $clog2(StoreDepth);
  localparam int DualBits   = 48;
  localparam int SlackBits  = 50;

  // Register indexes on the configuration port
  localparam logic RegRowCount    = 1'b0;
  localparam logic RegColumnCount = 1'b1;

  typedef struct packed {
    logic signed [31:0] entry_cost;
    logic               entry_infinite;
  } mca_in_t;

  typedef struct packed {
    logic               feasible;
    logic signed [47:0] total_cost;
    logic [3:0]         column_index;
    logic               column_matched;
    logic [2:0]         matched_row;
    logic signed [47:0] col_dual;
    logic signed [47:0] row_dual;
    logic               last_result;
  } mca_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_ROW_START,
    ST_STEP,
    ST_SC_RD,
    ST_SC_SUB,
    ST_SC_CMP,
    ST_SC_MIN,
    ST_SC_END,
    ST_UPD,
    ST_AUG,
    ST_TOT_RD,
    ST_TOT_ACC,
    ST_EMIT,
    ST_FAIL
  } mca_state_t;

  // Clamp a row count into 1..MaxRows
  function automatic logic [3:0] eff_rows(input logic [3:0] v);
    if (v == 4'd0) begin
      return 4'd1;
    end else if (int'(v) > MaxRows) begin
      return 4'(MaxRows);
    end
    return v;
  endfunction

  // Clamp a column count into 1..MaxColumns
  function automatic logic [4:0] eff_cols(input logic [4:0] v);
    if (v == 5'd0) begin
      return 5'd1;
    end else if (int'(v) > MaxColumns) begin
      return 5'(MaxColumns);
    end
    return v;
  endfunction

endpackage

>>> design/min_cost_assignment_hungarian.sv
// ----------------------------------------------------------------------------
// min_cost_assignment_hungarian
// Loads a cost matrix entry by entry, then solves the rectangular assignment
// with row and column potentials, scanning one column at a time.
// ----------------------------------------------------------------------------
// Loading: one entry per cycle while busy is low; the result side never stalls.
// Solve: scans the columns over the cost memory's read port (SC_RD, SC_SUB,
//   SC_CMP, SC_MIN per column), then totals the matched costs (TOT_RD, TOT_ACC).
// Results: one result per column, back to back (a single result on failure), then idle.
// Reset (rst_n low, synchronous): counts to 1, load position to 0, idle.
module min_cost_assignment_hungarian
  import mca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mca_in_t  in_entry,
  output logic     out_valid,
  output mca_out_t out_result,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [4:0] cfg_data
);

  mca_state_t state_r, state_nxt;

  logic [3:0] rows_r;
  logic [4:0] cols_r;
  logic [AddrBits-1:0] load_pos_r;
  logic [3:0] i_r, i0_r;
  logic [4:0] j_r, j0_r, j1_r, guard_r;
  logic       have_r, fin_r;
  logic signed [SlackBits-1:0] delta_r, t_r;
  logic signed [DualBits-1:0]  total_r;

  logic signed [DualBits-1:0]  u_r [MaxRows+1];
  logic signed [DualBits-1:0]  v_r [MaxColumns+1];
  logic [3:0]                  owner_r [MaxColumns+1];
  logic [4:0]                  path_r [MaxColumns+1];
  logic signed [SlackBits-1:0] slack_r [MaxColumns+1];
  logic [MaxColumns:0]         svalid_r, visited_r;

  logic [CostBits:0] mem [StoreDepth];
  logic [CostBits:0] rd_data_r;
  logic [AddrBits-1:0] rd_addr;

  logic [3:0] er;
  logic [4:0] ec;
  logic       accept, last_entry;
  logic [2:0] row_off;
  logic signed [SlackBits-1:0] cur, rd_cost;
  logic [3:0] tot_owner;
  logic [4:0] emit_col;

  assign er = eff_rows(rows_r);
  assign ec = eff_cols(cols_r);
  assign busy = (state_r != ST_LOAD);
  assign accept = start && !busy;
  assign last_entry = (8'(load_pos_r) + 8'd1 >= 8'(er) * 8'(ec));
  assign tot_owner = owner_r[j_r];
  assign row_off = (state_r == ST_TOT_RD) ? 3'(tot_owner - 4'd1) : 3'(i0_r - 4'd1);
  assign rd_addr = AddrBits'(8'(row_off) * 8'(ec) + 8'(j_r - 5'd1));
  assign rd_cost = SlackBits'(signed'(rd_data_r[CostBits-1:0]));
  assign cur = t_r - SlackBits'(v_r[j_r]);
  assign emit_col = j_r + 5'd1;

  // Cost memory: write on transfer, registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[load_pos_r] <= {!in_entry.entry_infinite, in_entry.entry_cost};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && last_entry) begin
          state_nxt = (5'(er) > ec) ? ST_FAIL : ST_INIT;
        end
      end
      ST_INIT:      state_nxt = ST_ROW_START;
      ST_ROW_START: state_nxt = ST_STEP;
      ST_STEP:      state_nxt = ST_SC_RD;
      ST_SC_RD:     state_nxt = ST_SC_SUB;
      ST_SC_SUB:    state_nxt = ST_SC_CMP;
      ST_SC_CMP:    state_nxt = ST_SC_MIN;
      ST_SC_MIN:    state_nxt = (j_r == ec) ? ST_SC_END : ST_SC_RD;
      ST_SC_END:    state_nxt = have_r ? ST_UPD : ST_FAIL;
      ST_UPD: begin
        if (j_r == ec) begin
          state_nxt = (owner_r[j1_r] != 4'd0) ? ST_STEP : ST_AUG;
        end
      end
      ST_AUG: begin
        if (path_r[j0_r] == 5'd0 || guard_r + 5'd1 > ec + 5'd1) begin
          state_nxt = (i_r == er) ? ST_TOT_RD : ST_ROW_START;
        end
      end
      ST_TOT_RD:    state_nxt = ST_TOT_ACC;
      ST_TOT_ACC: begin
        if (tot_owner != 4'd0 && !rd_data_r[CostBits]) begin
          state_nxt = ST_FAIL;
        end else if (j_r == ec) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_TOT_RD;
        end
      end
      ST_EMIT:      state_nxt = (emit_col == ec) ? ST_LOAD : ST_EMIT;
      ST_FAIL:      state_nxt = ST_LOAD;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration and load position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= 4'd1;
      cols_r     <= 5'd1;
      load_pos_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRowCount:    rows_r <= cfg_data[3:0];
        RegColumnCount: cols_r <= cfg_data;
        default:        rows_r <= rows_r;
      endcase
      load_pos_r <= '0;
    end else if (accept) begin
      load_pos_r <= last_entry ? '0 : load_pos_r + AddrBits'(1);
    end
  end

  // Solver datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_LOAD: begin
        i_r <= 4'd1;
      end
      ST_INIT: begin
        for (int k = 0; k <= MaxRows; k++) u_r[k] <= '0;
        for (int k = 0; k <= MaxColumns; k++) begin
          v_r[k]     <= '0;
          owner_r[k] <= '0;
          path_r[k]  <= '0;
        end
        i_r <= 4'd1;
      end
      ST_ROW_START: begin
        owner_r[0] <= i_r;
        svalid_r   <= '0;
        visited_r  <= '0;
        j0_r       <= '0;
      end
      ST_STEP: begin
        i0_r <= owner_r[j0_r];
        visited_r[j0_r] <= 1'b1;
        have_r <= 1'b0;
        j_r <= 5'd1;
      end
      ST_SC_RD: begin
        fin_r <= 1'b0;
      end
      ST_SC_SUB: begin
        t_r   <= rd_cost - SlackBits'(u_r[i0_r]);
        fin_r <= rd_data_r[CostBits];
      end
      ST_SC_CMP: begin
        // Tighten the slack of an unvisited column
        if (!visited_r[j_r] && fin_r && (!svalid_r[j_r] || cur < slack_r[j_r])) begin
          slack_r[j_r]  <= cur;
          svalid_r[j_r] <= 1'b1;
          path_r[j_r]   <= j0_r;
        end
      end
      ST_SC_MIN: begin
        // Track the smallest slack
        if (!visited_r[j_r] && svalid_r[j_r] && (!have_r || slack_r[j_r] < delta_r)) begin
          delta_r <= slack_r[j_r];
          have_r  <= 1'b1;
          j1_r    <= j_r;
        end
        j_r <= j_r + 5'd1;
      end
      ST_SC_END: begin
        j_r <= 5'd0;
      end
      ST_UPD: begin
        // Shift potentials by delta
        if (visited_r[j_r]) begin
          u_r[owner_r[j_r]] <= u_r[owner_r[j_r]] + DualBits'(delta_r);
          v_r[j_r] <= v_r[j_r] - DualBits'(delta_r);
        end else if (svalid_r[j_r]) begin
          slack_r[j_r] <= slack_r[j_r] - delta_r;
        end
        if (j_r == ec) begin
          j0_r    <= j1_r;
          guard_r <= '0;
        end
        j_r <= j_r + 5'd1;
      end
      ST_AUG: begin
        // Walk the path back and flip the matching
        owner_r[j0_r] <= owner_r[path_r[j0_r]];
        j0_r    <= path_r[j0_r];
        guard_r <= guard_r + 5'd1;
        if (path_r[j0_r] == 5'd0 || guard_r + 5'd1 > ec + 5'd1) begin
          i_r     <= i_r + 4'd1;
          j_r     <= 5'd1;
          total_r <= '0;
        end
      end
      ST_TOT_RD: begin
        fin_r <= 1'b0;
      end
      ST_TOT_ACC: begin
        if (tot_owner != 4'd0) begin
          total_r <= total_r + DualBits'(rd_cost);
        end
        j_r <= (j_r == ec) ? 5'd0 : j_r + 5'd1;
      end
      ST_EMIT: begin
        j_r <= j_r + 5'd1;
      end
      ST_FAIL: begin
        j_r <= '0;
      end
      default: begin
        j_r <= j_r;
      end
    endcase
  end

  // Drive the result strobe and payload
  always_comb begin
    out_valid  = 1'b0;
    out_result = '0;
    if (state_r == ST_FAIL) begin
      out_valid = 1'b1;
      out_result.last_result = 1'b1;
    end else if (state_r == ST_EMIT) begin
      out_valid = 1'b1;
      out_result.feasible         = 1'b1;
      out_result.total_cost       = total_r;
      out_result.column_index     = j_r[3:0];
      out_result.column_matched   = (owner_r[emit_col] != 4'd0);
      out_result.matched_row      = (owner_r[emit_col] != 4'd0) ?
                                    3'(owner_r[emit_col] - 4'd1) : 3'd0;
      out_result.col_dual         = v_r[emit_col];
      out_result.row_dual         = (4'(j_r) < er) ? u_r[4'(emit_col)] : '0;
      out_result.last_result      = (emit_col == ec);
    end
  end

endmodule

>>> design/mca_checker.sv
// ----------------------------------------------------------------------------
// mca_checker
// Port-level checks on result sequencing of the assignment solver.
// ----------------------------------------------------------------------------
module mca_checker
  import mca_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     busy,
  input logic     out_valid,
  input mca_out_t out_result
);

  // Results only appear while the block is busy
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy window");

  // A failure result is always the last one
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result.feasible |-> out_result.last_result)
    else $error("failure result not marked last");

  // Results of one run come back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result.last_result |=> out_valid)
    else $error("gap inside result burst");

  // The block goes idle after the last result
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.last_result |=> !busy && !out_valid)
    else $error("not idle after last result");

endmodule

bind min_cost_assignment_hungarian mca_checker u_mca_checker (
  .clk(clk),
  .rst_n(rst_n),
  .busy(busy),
  .out_valid(out_valid),
  .out_result(out_result)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the min-cost assignment solver: loads cost
// matrices under several row/column settings, predicts every result with a
// behavioral Hungarian solver and compares each strobed result in order.
// ----------------------------------------------------------------------------
module tb
  import mca_pkg::*;
();

  localparam int CycleLimit = 3000000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  mca_in_t    in_entry;
  logic       out_valid;
  mca_out_t   out_result;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_data;

  min_cost_assignment_hungarian DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_entry  (in_entry),
    .out_valid (out_valid),
    .out_result(out_result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state
  logic [3:0]      row_reg;
  logic [4:0]      col_reg;
  longint          mtx_cost [StoreDepth];
  bit              mtx_fin  [StoreDepth];
  int              load_pos;
  longint          u_dual [MaxRows + 1];
  longint          v_dual [MaxColumns + 1];
  int              owner  [MaxColumns + 1];
  int              way    [MaxColumns + 1];
  longint          minv   [MaxColumns + 1];
  bit              minv_ok[MaxColumns + 1];
  bit              used   [MaxColumns + 1];

  mca_out_t        pending_results[$];
  int              errors;
  int              n_results;
  int              n_fail_results;
  int              n_items;
  longint          cycles;

  // Directed table: cost, infinite flag, typed expectation present
  typedef struct {
    logic signed [31:0] cost;
    logic               inf;
    bit                 chk;
  } entry_row_t;

  entry_row_t dir_tab[$];

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Abort on runaway
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("FAILURE");
      $finish;
    end
  end

  // Run the Hungarian method on the loaded matrix; 0 when infeasible
  function automatic bit solve_assignment(input int nr, input int nc,
                                          output longint total);
    int     j0, j1, i0, g;
    longint delta, cur;
    bit     have;
    total = 0;
    for (int k = 0; k <= MaxRows; k++) u_dual[k] = 0;
    for (int k = 0; k <= MaxColumns; k++) begin
      v_dual[k] = 0; owner[k] = 0; way[k] = 0;
    end
    for (int i = 1; i <= nr; i++) begin
      owner[0] = i;
      j0 = 0;
      for (int k = 0; k <= MaxColumns; k++) begin
        minv_ok[k] = 0; used[k] = 0;
      end
      do begin
        i0 = owner[j0];
        j1 = 0;
        delta = 0;
        have = 0;
        used[j0] = 1;
        for (int j = 1; j <= nc; j++) begin
          if (!used[j]) begin
            if (i0 >= 1 && mtx_fin[(i0 - 1) * nc + j - 1]) begin
              cur = mtx_cost[(i0 - 1) * nc + j - 1] - u_dual[i0] - v_dual[j];
              if (!minv_ok[j] || cur < minv[j]) begin
                minv[j] = cur; minv_ok[j] = 1; way[j] = j0;
              end
            end
            if (minv_ok[j] && (!have || minv[j] < delta)) begin
              delta = minv[j]; have = 1; j1 = j;
            end
          end
        end
        if (!have) return 0;
        for (int j = 0; j <= nc; j++) begin
          if (used[j]) begin
            u_dual[owner[j] % (MaxRows + 1)] += delta;
            v_dual[j] -= delta;
          end else if (minv_ok[j]) begin
            minv[j] -= delta;
          end
        end
        j0 = j1;
      end while (owner[j0] != 0);
      g = 0;
      do begin
        j1 = way[j0] % (MaxColumns + 1);
        owner[j0] = owner[j1];
        j0 = j1;
        g++;
      end while (j0 != 0 && g <= nc + 1);
    end
    for (int j = 1; j <= nc; j++) begin
      if (owner[j] != 0) begin
        if (!mtx_fin[(owner[j] - 1) * nc + j - 1]) return 0;
        total += mtx_cost[(owner[j] - 1) * nc + j - 1];
      end
    end
    return 1;
  endfunction

  // Record one accepted entry and queue the results it completes
  task automatic predict_entry(input mca_in_t e);
    int       nr, nc;
    longint   total;
    bit       ok;
    mca_out_t r;
    nr = int'(eff_rows(row_reg));
    nc = int'(eff_cols(col_reg));
    mtx_cost[load_pos] = longint'(e.entry_cost);
    mtx_fin[load_pos]  = !e.entry_infinite;
    load_pos++;
    if (load_pos < nr * nc) return;
    load_pos = 0;
    ok = (nr <= nc) && solve_assignment(nr, nc, total);
    if (!ok) begin
      r = '0;
      r.last_result = 1'b1;
      pending_results = {pending_results, r};
      return;
    end
    for (int j = 0; j < nc; j++) begin
      r.feasible         = 1'b1;
      r.total_cost       = total[47:0];
      r.column_index     = j[3:0];
      r.column_matched   = owner[j + 1] != 0;
      r.matched_row      = owner[j + 1] != 0 ? 3'(owner[j + 1] - 1) : 3'd0;
      r.col_dual         = v_dual[j + 1][47:0];
      r.row_dual         = j < nr ? u_dual[j + 1][47:0] : 48'sd0;
      r.last_result      = (j + 1 == nc);
      pending_results = {pending_results, r};
    end
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    mca_out_t exp_r;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_result);
      end else begin
        exp_r = pending_results.pop_front();
        if (!exp_r.feasible) n_fail_results++;
        if (out_result !== exp_r) begin
          errors++;
          $display("%0t mismatch col %0d: expected %h actual %h", $time,
                   exp_r.column_index, exp_r, out_result);
          if (out_result.total_cost !== exp_r.total_cost)
            $display("  total_cost expected %0d actual %0d",
                     exp_r.total_cost, out_result.total_cost);
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegRowCount) row_reg = val[3:0];
    else col_reg = val;
    load_pos = 0;
  endtask

  // Drop start, wait for all results, then for the solver to settle to idle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_shape(input logic [3:0] nr, input logic [4:0] nc);
    drain();
    write_reg(RegRowCount, {1'b0, nr});
    write_reg(RegColumnCount, nc);
  endtask

  // Transfer one entry, holding start until busy is low
  task automatic send_entry(input mca_in_t e, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start    <= 1'b1;
    in_entry <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_entry(e);
    n_items++;
  endtask

  function automatic mca_in_t rand_entry(input int inf_pct, input bit wide);
    mca_in_t e;
    e.entry_cost = wide ? $urandom() : $signed($urandom_range(0, 200)) - 100;
    if (wide && $urandom_range(0, 3) == 0)
      e.entry_cost = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    e.entry_infinite = $urandom_range(0, 99) < inf_pct;
    return e;
  endfunction

  // Load one whole matrix of the current shape
  task automatic send_matrix(input int inf_pct, input bit wide, input bit gaps);
    int n;
    n = int'(eff_rows(row_reg)) * int'(eff_cols(col_reg));
    for (int k = 0; k < n; k++) send_entry(rand_entry(inf_pct, wide), gaps);
  endtask

  initial begin
    mca_in_t  e;
    mca_out_t want;
    int       nr, nc;
    rst_n = 1'b0; start = 1'b0; in_entry = '0;
    cfg_we = 1'b0; cfg_index = RegRowCount; cfg_data = '0;
    errors = 0; n_results = 0; n_fail_results = 0; n_items = 0; cycles = 0;
    row_reg = 4'd1; col_reg = 5'd1; load_pos = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 1x1 extremes and infinite, each with a typed expectation
    dir_tab = '{'{32'sh7fffffff, 1'b0, 1'b1}, '{32'sh80000000, 1'b0, 1'b1},
                '{32'sd0, 1'b1, 1'b1}, '{-32'sd1, 1'b0, 1'b1}};
    foreach (dir_tab[k]) begin
      e.entry_cost = dir_tab[k].cost;
      e.entry_infinite = dir_tab[k].inf;
      send_entry(e, 0);
      if (dir_tab[k].chk) begin
        // 1x1: finite cost lands in total and row dual; infinite fails
        want = '0;
        want.last_result = 1'b1;
        if (!dir_tab[k].inf) begin
          want.feasible       = 1'b1;
          want.total_cost     = 48'(dir_tab[k].cost);
          want.column_matched = 1'b1;
          want.row_dual       = 48'(dir_tab[k].cost);
        end
        if (pending_results[$] !== want) begin
          errors++;
          $display("%0t directed row %0d: expected %h predicted %h", $time, k,
                   want, pending_results[$]);
        end
      end
      if (k == 2) begin
        // Infinite 1x1 entry: single failure result
        drain();
      end
    end
    // 2x2: row 0 all infinite, then a feasible matrix
    set_shape(4'd2, 5'd2);
    dir_tab = '{'{32'sd5, 1'b1, 1'b0}, '{32'sd7, 1'b1, 1'b0}, '{32'sd1, 1'b0, 1'b0},
                '{32'sd2, 1'b0, 1'b0}, '{32'sd4, 1'b0, 1'b0}, '{32'sd1, 1'b1, 1'b0},
                '{-32'sd3, 1'b0, 1'b0}, '{32'sd9, 1'b0, 1'b0}};
    foreach (dir_tab[k]) begin
      e.entry_cost = dir_tab[k].cost;
      e.entry_infinite = dir_tab[k].inf;
      send_entry(e, 0);
    end
    // More rows than columns, and out-of-range counts (0 and saturation)
    set_shape(4'd3, 5'd2);
    send_matrix(0, 0, 0);
    set_shape(4'd0, 5'd0);
    send_matrix(0, 1, 0);
    set_shape(4'd15, 5'd31);
    send_matrix(10, 1, 0);

    // Random shapes, mostly small; the last stretch runs without gaps
    while (n_items < 410) begin
      nr = $urandom_range(0, 9) == 0 ? 8 : $urandom_range(1, 4);
      nc = $urandom_range(0, 9) == 0 ? 16 : $urandom_range(nr, nr + 3);
      if ($urandom_range(0, 7) == 0) nc = $urandom_range(1, 16);
      if (nr * nc > 420 - n_items) begin
        nr = 1;
        nc = 1;
      end
      set_shape(nr[3:0], nc[4:0]);
      repeat ($urandom_range(1, 3)) begin
        if (n_items < 410 && n_items + nr * nc <= 420)
          send_matrix($urandom_range(0, 40), $urandom_range(0, 3) == 0, n_items < 340);
      end
    end
    drain();
    repeat (20) @(posedge clk);
    $display("Loaded %0d entries over varied shapes; %0d results checked, %0d infeasible.",
             n_items, n_results, n_fail_results);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mca_pkg.sv
design/min_cost_assignment_hungarian.sv
design/mca_checker.sv
verif/tb.sv
